// ===== rtl/stopwatch_digit_formatter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter assertion macros
// Shared property shorthands for the checker of the formatter core.
// ----------------------------------------------------------------------------
`ifndef STOPWATCH_DIGIT_FORMATTER_CORE_MACROS_SVH
`define STOPWATCH_DIGIT_FORMATTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter package
// Shared widths, register map, glyph codes, item types and the constant
// divider used by the conversion stages.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int TICK_W    = 58;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;
    localparam int REG_SHIFT = 3;
    localparam int QDEPTH    = 2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;
    localparam logic [1:0] REG_WIDTH = 2'd3;

    localparam logic [1:0] KIND_UP      = 2'd1;
    localparam logic [1:0] KIND_LOW     = 2'd2;
    localparam logic [1:0] KIND_SAMPLED = 2'd3;

    localparam logic [3:0] MODE_SHORT_MASK  = 4'hC;
    localparam logic [3:0] MODE_SHORT_VAL   = 4'h4;
    localparam logic [3:0] MODE_FORCE_SHORT = 4'h8;

    localparam logic [7:0] WIDTH_RESET = 8'd8;

    localparam logic [3:0] GLYPH_SEP   = 4'd10;
    localparam logic [3:0] GLYPH_BLANK = 4'd11;

    localparam logic [15:0] DIVISOR     = 16'h82EA;
    localparam logic [31:0] MS_PER_MIN  = 32'd60000;
    localparam logic [31:0] SHORT_ROUND = 32'd99;
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP6      = 32'hAAAA_AAAB;

    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic              kind2;
        logic              short_form;
        logic [7:0]        col;
    } item_t;

    typedef struct packed {
        logic [31:0] x;
        logic        low;
        logic        short_form;
        logic [7:0]  col;
    } div_res_t;

    // Exact quotient by 10 or 6 for any 32-bit value, by reciprocal multiply.
    function automatic logic [31:0] div_by_const(input logic [31:0] x, input logic by_six);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, (by_six ? RECIP6 : RECIP10)};
        return by_six ? {2'd0, prod[63:34]} : {3'd0, prod[63:35]};
    endfunction

endpackage

// ===== rtl/sdf_front.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter front end
// Holds the configuration registers, accepts requests and reduces each one
// to the tick value and display flags that the back end needs.
// ----------------------------------------------------------------------------
module sdf_front
    import sdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [TICK_W-1:0] elapsed_ticks,
    input  logic [TICK_W-1:0] sampled_ticks,
    input  logic              q_full,
    output logic              item_valid,
    output item_t             item
);

    logic [1:0]        kind_reg;
    logic [TICK_W-1:0] limit_reg;
    logic [3:0]        display_mode_reg;
    logic [7:0]        width_reg;
    logic              fv_reg;
    logic              fv_next;
    item_t             item_reg;

    logic [1:0]        reg_idx;
    logic              wr_en;
    logic              accept;
    logic              push;
    logic              short_sel;
    logic [TICK_W-1:0] ticks_sel;

    assign reg_idx = paddr[APB_AW-1:REG_SHIFT];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        case (reg_idx)
            REG_KIND:  prdata = {{(APB_DW-2){1'b0}}, kind_reg};
            REG_LIMIT: prdata = {{(APB_DW-TICK_W){1'b0}}, limit_reg};
            REG_MODE:  prdata = {{(APB_DW-4){1'b0}}, display_mode_reg};
            REG_WIDTH: prdata = {{(APB_DW-8){1'b0}}, width_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= '0;
            limit_reg        <= '0;
            display_mode_reg <= '0;
            width_reg        <= WIDTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KIND:  kind_reg         <= pwdata[1:0];
                REG_LIMIT: limit_reg        <= pwdata[TICK_W-1:0];
                REG_MODE:  display_mode_reg <= pwdata[3:0];
                REG_WIDTH: width_reg        <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    // Past the limit, a count-up shows the limit and a count-down shows zero.
    always_comb
    begin
        if (kind_reg == KIND_SAMPLED)
            ticks_sel = sampled_ticks;
        else if (elapsed_ticks < limit_reg)
            ticks_sel = (kind_reg == KIND_UP) ? elapsed_ticks : limit_reg - elapsed_ticks;
        else
            ticks_sel = (kind_reg == KIND_UP) ? limit_reg : '0;
    end

    assign short_sel = ((display_mode_reg & MODE_SHORT_MASK) == MODE_SHORT_VAL)
                    || ((display_mode_reg & MODE_FORCE_SHORT) != 4'h0);

    // The front register frees itself whenever the queue has room.
    assign busy   = fv_reg && q_full;
    assign accept = start && !busy;
    assign push   = fv_reg && !q_full;

    always_comb
    begin
        fv_next = fv_reg;
        if (accept)
            fv_next = 1'b1;
        else if (push)
            fv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.ticks      <= ticks_sel;
            item_reg.kind2      <= (kind_reg == KIND_LOW);
            item_reg.short_form <= short_sel;
            item_reg.col        <= width_reg - 8'd1;
        end
    end

    assign item_valid = push;
    assign item       = item_reg;

endmodule

// ===== rtl/sdf_queue.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter request queue
// A short first-in first-out buffer between the front end and the divider.
// ----------------------------------------------------------------------------
module sdf_queue
    import sdf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  nonempty
);

    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/sdf_div.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter tick divider
// Long division of the shifted tick count by the tick rate, seven quotient
// bits per cycle, then a hand-off stage that forms centiseconds and the
// lower-row flag.
// ----------------------------------------------------------------------------
module sdf_div
    import sdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  item_t    q_item,
    output logic     pop,
    output logic     res_valid,
    output div_res_t res,
    input  logic     res_take
);

    // The dividend is the tick count shifted left by six. Its top fifteen
    // bits stay below the divisor, so they seed the remainder directly.
    localparam int TOP_W   = 15;
    localparam int REST_W  = TICK_W + 6 - TOP_W;
    localparam int STEP_N  = 7;
    localparam int CNT_W   = 3;

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [15:0]       rem_reg;
    logic [REST_W-1:0] bits_reg;
    logic [31:0]       quo_reg;
    logic              kind2_reg;
    logic              short_reg;
    logic [7:0]        col_reg;
    logic              rv_reg;
    logic              rv_next;
    div_res_t          res_reg;

    logic              xfer;
    logic              load;
    logic [15:0]       step_r;
    logic [REST_W-1:0] step_b;
    logic [31:0]       step_q;
    logic [16:0]       trial;

    assign xfer = (state_reg == DV_DONE) && (!rv_reg || res_take);
    assign load = q_valid && ((state_reg == DV_IDLE) || xfer);
    assign pop  = load;

    always_comb
    begin
        step_r = rem_reg;
        step_b = bits_reg;
        step_q = quo_reg;
        trial  = '0;
        for (int i = 0; i < STEP_N; i++)
        begin
            trial  = {step_r, step_b[REST_W-1]};
            step_b = {step_b[REST_W-2:0], 1'b0};
            if (trial >= {1'b0, DIVISOR})
            begin
                step_r = 16'(trial - {1'b0, DIVISOR});
                step_q = {step_q[30:0], 1'b1};
            end
            else
            begin
                step_r = trial[15:0];
                step_q = {step_q[30:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (load)
                    state_next = DV_RUN;
            end
            DV_RUN:
            begin
                if (cnt_reg == '0)
                    state_next = DV_DONE;
            end
            DV_DONE:
            begin
                if (load)
                    state_next = DV_RUN;
                else if (xfer)
                    state_next = DV_IDLE;
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (xfer)
            rv_next = 1'b1;
        else if (res_take)
            rv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg   <= {1'b0, q_item.ticks[TICK_W-1 -: TOP_W]};
            bits_reg  <= {q_item.ticks[TICK_W-TOP_W-1:0], 6'd0};
            quo_reg   <= '0;
            cnt_reg   <= CNT_W'(REST_W / STEP_N - 1);
            kind2_reg <= q_item.kind2;
            short_reg <= q_item.short_form;
            col_reg   <= q_item.col;
        end
        else if (state_reg == DV_RUN)
        begin
            rem_reg  <= step_r;
            bits_reg <= step_b;
            quo_reg  <= step_q;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            res_reg.x          <= div_by_const(quo_reg, 1'b0);
            res_reg.low        <= kind2_reg && (quo_reg < MS_PER_MIN);
            res_reg.short_form <= short_reg;
            res_reg.col        <= col_reg;
        end
    end

    assign res_valid = rv_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/sdf_emit.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter glyph emitter
// Peels one digit per cycle off the centisecond value, none on a separator,
// and drives one glyph write per cycle, rightmost glyph first.
// ----------------------------------------------------------------------------
module sdf_emit
    import sdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  div_res_t in_res,
    output logic     take,
    output logic     strobe,
    output logic [7:0] column,
    output logic [3:0] glyph,
    output logic     lower_row,
    output logic     last
);

    localparam logic [1:0] EM_IDLE  = 2'd0;
    localparam logic [1:0] EM_PREP1 = 2'd1;
    localparam logic [1:0] EM_PREP2 = 2'd2;
    localparam logic [1:0] EM_GLYPH = 2'd3;

    localparam logic [2:0] STEP_SEP_CS      = 3'd2;
    localparam logic [2:0] STEP_FIRST_SHORT = 3'd3;
    localparam logic [2:0] STEP_S_TENS      = 3'd4;
    localparam logic [2:0] STEP_SEP_MIN     = 3'd5;
    localparam logic [2:0] STEP_LAST        = 3'd7;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [31:0] val_reg;
    logic [31:0] val_next;
    logic [7:0]  col_reg;
    logic        low_reg;
    logic        strobe_reg;
    logic [7:0]  column_reg;
    logic [3:0]  glyph_reg;
    logic        lower_row_reg;
    logic        last_reg;

    logic        ready;
    logic        by_six;
    logic        is_sep;
    logic [31:0] mul_in;
    logic [31:0] quot;
    logic [31:0] quot_k;
    logic [3:0]  digit;
    logic [3:0]  glyph_next;

    assign ready = (state_reg == EM_IDLE) || ((state_reg == EM_GLYPH) && (step_reg == STEP_LAST));
    assign take  = in_valid && ready;

    assign by_six = (state_reg == EM_GLYPH) && (step_reg == STEP_S_TENS);
    assign is_sep = step_reg inside {STEP_SEP_CS, STEP_SEP_MIN};

    // Short form rounds up to whole seconds: (cs + 99) / 10 / 10.
    assign mul_in = (state_reg == EM_PREP1) ? val_reg + SHORT_ROUND : val_reg;
    assign quot   = div_by_const(mul_in, by_six);
    assign quot_k = by_six ? (quot << 2) + (quot << 1) : (quot << 3) + (quot << 1);
    assign digit  = 4'(val_reg - quot_k);

    always_comb
    begin
        if (is_sep)
            glyph_next = GLYPH_SEP;
        else if ((step_reg == STEP_LAST) && (val_reg == '0))
            glyph_next = GLYPH_BLANK;
        else
            glyph_next = digit;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        val_next   = val_reg;
        case (state_reg)
            EM_IDLE: ;
            EM_PREP1:
            begin
                val_next   = quot;
                state_next = EM_PREP2;
            end
            EM_PREP2:
            begin
                val_next   = quot;
                state_next = EM_GLYPH;
            end
            EM_GLYPH:
            begin
                if (!is_sep)
                    val_next = quot;
                if (step_reg == STEP_LAST)
                    state_next = EM_IDLE;
                else
                    step_next = step_reg + 3'd1;
            end
            default: state_next = EM_IDLE;
        endcase
        if (take)
        begin
            val_next   = in_res.x;
            state_next = in_res.short_form ? EM_PREP1 : EM_GLYPH;
            step_next  = in_res.short_form ? STEP_FIRST_SHORT : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EM_IDLE;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            strobe_reg <= (state_reg == EM_GLYPH);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        column_reg    <= col_reg - {5'd0, step_reg};
        glyph_reg     <= glyph_next;
        lower_row_reg <= low_reg;
        last_reg      <= (step_reg == STEP_LAST);
        if (take)
        begin
            col_reg <= in_res.col;
            low_reg <= in_res.low;
        end
    end

    assign strobe    = strobe_reg;
    assign column    = column_reg;
    assign glyph     = glyph_reg;
    assign lower_row = lower_row_reg;
    assign last      = last_reg && strobe_reg;

endmodule

// ===== rtl/stopwatch_digit_formatter_core.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter core
// Turns one stopwatch tick count into the glyph writes of an MM:SS.cc display.
//
// Configuration goes through the APB port (kind, limit, display_mode, width at
// byte addresses 0, 8, 16, 24), to be written by the user while the core is
// idle; the core does not enforce this. A request is accepted on a clock edge
// with start high and busy low; it carries elapsed_ticks and sampled_ticks.
// Each request yields eight glyph writes in long form or five in short form,
// rightmost first, one per cycle, each shown for one cycle with strobe high;
// last marks the final one. Short form adds the emitter's rounding prep stages
// before the first glyph. The divider retires seven quotient bits per cycle
// and loads the next request as it hands a result on. busy rises only when
// the front register and the two-entry queue ahead of the divider are both
// full. Results cannot be held off by the receiver. Reset returns the
// registers to kind 0, limit 0, display_mode 0, width 8 and empties the
// pipeline.
// ----------------------------------------------------------------------------
module stopwatch_digit_formatter_core
    import sdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [TICK_W-1:0] elapsed_ticks,
    input  logic [TICK_W-1:0] sampled_ticks,
    output logic              strobe,
    output logic [7:0]        column,
    output logic [3:0]        glyph,
    output logic              lower_row,
    output logic              last
);

    logic     q_full;
    logic     q_nonempty;
    logic     push;
    logic     pop;
    item_t    push_item;
    item_t    head;
    logic     res_valid;
    logic     res_take;
    div_res_t res;

    sdf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .elapsed_ticks (elapsed_ticks),
        .sampled_ticks (sampled_ticks),
        .q_full        (q_full),
        .item_valid    (push),
        .item          (push_item)
    );

    sdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .nonempty  (q_nonempty)
    );

    sdf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .q_item    (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    sdf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .take      (res_take),
        .strobe    (strobe),
        .column    (column),
        .glyph     (glyph),
        .lower_row (lower_row),
        .last      (last)
    );

endmodule

// ===== rtl/sdf_checker.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter checker
// Watches the result port of the core for the shape of a glyph run.
// ----------------------------------------------------------------------------
`include "stopwatch_digit_formatter_core_macros.svh"

module sdf_checker
    import sdf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [7:0] column,
    input logic [3:0] glyph,
    input logic       lower_row,
    input logic       last
);

    // Glyphs of one value come out back to back, one column further left each.
    `SDF_ASSERT_NEXT(a_col_step, strobe && !last, strobe && (column == $past(column) - 8'd1), "glyph run broken or column skipped")

    `SDF_ASSERT_NEXT(a_low_steady, strobe && !last, lower_row == $past(lower_row), "lower_row changed within a value")

    `SDF_ASSERT_SAME(a_sep_not_last, strobe && (glyph == GLYPH_SEP), !last, "separator marked as final glyph")

    `SDF_ASSERT_NEXT(a_sep_alone, strobe && (glyph == GLYPH_SEP), strobe && (glyph != GLYPH_SEP), "two separators in a row")

endmodule

bind stopwatch_digit_formatter_core sdf_checker u_sdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .strobe    (strobe),
    .column    (column),
    .glyph     (glyph),
    .lower_row (lower_row),
    .last      (last)
);

// ===== bench/stopwatch_glyph_checker.sv =====
// ----------------------------------------------------------------------------
// Stopwatch glyph write checker
// Watches the APB port, the request handshake and the glyph write strobe of
// the digit formatter core. It keeps its own copy of the registers, works out
// the glyph writes of every accepted request and compares each strobed write,
// field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module stopwatch_glyph_checker
    import sdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              start,
    input  logic              busy,
    input  logic [TICK_W-1:0] elapsed_ticks,
    input  logic [TICK_W-1:0] sampled_ticks,
    input  logic              strobe,
    input  logic [7:0]        column,
    input  logic [3:0]        glyph,
    input  logic              lower_row,
    input  logic              last,
    output int                mismatches,
    output int                outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] column;
        logic [3:0] glyph;
        logic       lower_row;
        logic       last;
    } glyph_write_t;

    glyph_write_t      glyph_writes_q[$];
    logic [1:0]        kind_cfg;
    logic [TICK_W-1:0] limit_cfg;
    logic [3:0]        mode_cfg;
    logic [7:0]        width_cfg;

    initial mismatches = 0;

    function automatic glyph_write_t glyph_write(input logic [7:0] col, input logic [3:0] g,
                                                 input logic low);
        glyph_write_t w;
        w.column    = col;
        w.glyph     = g;
        w.lower_row = low;
        w.last      = 1'b0;
        return w;
    endfunction

    task automatic predict_glyph_writes(input logic [TICK_W-1:0] elapsed,
                                        input logic [TICK_W-1:0] sampled);
        logic [TICK_W-1:0] ticks;
        logic [63:0]       scaled;
        logic [31:0]       ms;
        logic [31:0]       v;
        logic [7:0]        col;
        logic              low;
        logic              short_form;
        glyph_write_t      seq[8];
        int                n;
        if (kind_cfg == KIND_SAMPLED)
            ticks = sampled;
        else if (elapsed < limit_cfg)
            ticks = (kind_cfg == KIND_UP) ? elapsed : limit_cfg - elapsed;
        else
            ticks = (kind_cfg == KIND_UP) ? limit_cfg : '0;

        // The millisecond value keeps only the low 32 bits of the quotient.
        scaled = {ticks, 6'd0} / {48'd0, DIVISOR};
        ms     = scaled[31:0];
        low    = (kind_cfg == KIND_LOW) && (ms < MS_PER_MIN);
        v      = ms / 32'd10;
        col    = width_cfg - 8'd1;
        n      = 0;
        short_form = ((mode_cfg & MODE_SHORT_MASK) == MODE_SHORT_VAL) ||
                     ((mode_cfg & MODE_FORCE_SHORT) != 4'd0);

        if (short_form) begin
            // Short form rounds centiseconds up to whole seconds.
            col = col - 8'd3;
            v   = (v + SHORT_ROUND) / 32'd100;
        end else begin
            seq[0] = glyph_write(col, 4'(v % 32'd10), low);
            v      = v / 32'd10;
            seq[1] = glyph_write(col - 8'd1, 4'(v % 32'd10), low);
            v      = v / 32'd10;
            seq[2] = glyph_write(col - 8'd2, GLYPH_SEP, low);
            col    = col - 8'd3;
            n      = 3;
        end

        seq[n]     = glyph_write(col, 4'(v % 32'd10), low);
        v          = v / 32'd10;
        seq[n + 1] = glyph_write(col - 8'd1, 4'(v % 32'd6), low);
        v          = v / 32'd6;
        seq[n + 2] = glyph_write(col - 8'd2, GLYPH_SEP, low);
        seq[n + 3] = glyph_write(col - 8'd3, 4'(v % 32'd10), low);
        seq[n + 4] = glyph_write(col - 8'd4,
                                 (v / 32'd10 != 32'd0) ? 4'((v / 32'd10) % 32'd10) : GLYPH_BLANK,
                                 low);
        n = n + 5;
        seq[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            glyph_writes_q.push_back(seq[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        glyph_write_t got;
        glyph_write_t want;
        if (!rst_n)
        begin
            kind_cfg  <= '0;
            limit_cfg <= '0;
            mode_cfg  <= '0;
            width_cfg <= WIDTH_RESET;
            glyph_writes_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (strobe)
            begin
                got = {column, glyph, lower_row, last};
                if (glyph_writes_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: glyph write with no request pending: col %0d glyph %0d lower_row %0b last %0b",
                                 $time, got.column, got.glyph, got.lower_row, got.last);
                end
                else
                begin
                    want = glyph_writes_q.pop_front();
                    if (got.column !== want.column || got.glyph !== want.glyph ||
                        got.lower_row !== want.lower_row || got.last !== want.last)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: glyph write mismatch: expected col %0d glyph %0d lower_row %0b last %0b, got col %0d glyph %0d lower_row %0b last %0b",
                                     $time, want.column, want.glyph, want.lower_row, want.last,
                                     got.column, got.glyph, got.lower_row, got.last);
                    end
                end
            end

            if (start && !busy)
                predict_glyph_writes(elapsed_ticks, sampled_ticks);

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_AW-1:REG_SHIFT])
                    REG_KIND:  kind_cfg  <= pwdata[1:0];
                    REG_LIMIT: limit_cfg <= pwdata[TICK_W-1:0];
                    REG_MODE:  mode_cfg  <= pwdata[3:0];
                    REG_WIDTH: width_cfg <= pwdata[7:0];
                    default:   ;
                endcase
            end

            outstanding <= glyph_writes_q.size();
        end
    end

endmodule

// ===== bench/tb_stopwatch_digit_formatter_core.sv =====
// ----------------------------------------------------------------------------
// Stopwatch digit formatter core testbench
// Drives directed and random tick counts through the core under a series of
// register settings, with random request gaps and one long stretch without
// them. The glyph writes are checked by the checker beside the core; this
// module gives the verdict once every expected write has arrived.
// ----------------------------------------------------------------------------
module tb_stopwatch_digit_formatter_core;
    import sdf_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 33;
    localparam int QUIET_PHASE     = 4;

    localparam logic [TICK_W-1:0] TICK_MAX      = '1;
    localparam logic [TICK_W-1:0] ALT_A         = {29{2'b10}};
    localparam logic [TICK_W-1:0] ALT_B         = {29{2'b01}};
    // Roughly 60000 ms worth of ticks, and one hundred minutes.
    localparam logic [TICK_W-1:0] TICKS_PER_MIN = 58'd31419375;
    localparam logic [TICK_W-1:0] TICKS_100_MIN = 58'd3141937500;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              start         = 1'b0;
    logic              busy;
    logic [TICK_W-1:0] elapsed_ticks = '0;
    logic [TICK_W-1:0] sampled_ticks = '0;
    logic              strobe;
    logic [7:0]        column;
    logic [3:0]        glyph;
    logic              lower_row;
    logic              last;
    int                mismatches;
    int                outstanding;
    logic              gaps_on       = 1'b1;

    stopwatch_digit_formatter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .elapsed_ticks (elapsed_ticks),
        .sampled_ticks (sampled_ticks),
        .strobe        (strobe),
        .column        (column),
        .glyph         (glyph),
        .lower_row     (lower_row),
        .last          (last)
    );

    stopwatch_glyph_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .start         (start),
        .busy          (busy),
        .elapsed_ticks (elapsed_ticks),
        .sampled_ticks (sampled_ticks),
        .strobe        (strobe),
        .column        (column),
        .glyph         (glyph),
        .lower_row     (lower_row),
        .last          (last),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << REG_SHIFT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stops issuing requests and waits until every predicted glyph write is in.
    task automatic drain_glyph_writes();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] kind, input logic [TICK_W-1:0] lim,
                             input logic [3:0] mode, input logic [7:0] wid);
        drain_glyph_writes();
        write_reg(REG_KIND, APB_DW'(kind));
        write_reg(REG_LIMIT, APB_DW'(lim));
        write_reg(REG_MODE, APB_DW'(mode));
        write_reg(REG_WIDTH, APB_DW'(wid));
    endtask

    // Returns after the first edge that leaves busy low, with start still high.
    task automatic send_request(input logic [TICK_W-1:0] elapsed,
                                input logic [TICK_W-1:0] sampled);
        int gap;
        if (gaps_on && $urandom_range(99) < 21)
        begin
            gap = $urandom_range(12, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        elapsed_ticks <= elapsed;
        sampled_ticks <= sampled;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Random magnitude first, so that small and huge counts are both common.
    function automatic logic [TICK_W-1:0] random_ticks();
        logic [63:0]       raw;
        logic [TICK_W-1:0] mask;
        int                bits;
        raw  = {$urandom, $urandom};
        bits = $urandom_range(TICK_W, 0);
        mask = (TICK_W'(1) << bits) - TICK_W'(1);
        return raw[TICK_W-1:0] & mask;
    endfunction

    initial
    begin : stimulus
        logic [1:0]        kind;
        logic [TICK_W-1:0] lim;
        logic [3:0]        mode;
        logic [7:0]        wid;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] delta;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers as left by reset.
        send_request('0, '0);
        send_request(TICK_MAX, TICK_MAX);

        configure(KIND_SAMPLED, '0, 4'd3, WIDTH_RESET);
        send_request(ALT_A, '0);
        send_request(ALT_B, TICKS_100_MIN);
        send_request('0, TICKS_100_MIN - 58'd5500);
        send_request(TICK_MAX, ALT_A);
        send_request('0, ALT_B);

        // Count up past one hundred minutes with a zero width buffer.
        lim = 58'd40000000000;
        configure(KIND_UP, lim, 4'd0, 8'd0);
        send_request('0, TICK_MAX);
        send_request(lim - 58'd1, '0);
        send_request(lim, '0);
        send_request(lim + 58'd1, '0);
        send_request(TICK_MAX, '0);

        // Count down across the one minute mark for the lower row flag.
        lim = TICKS_PER_MIN * 2;
        configure(KIND_LOW, lim, 4'd4, 8'd255);
        send_request('0, '0);
        send_request(lim - TICKS_PER_MIN + 58'd1, '0);
        send_request(lim - TICKS_PER_MIN - 58'd600, '0);
        send_request(lim, '0);

        // Count down from the largest limit overflows the millisecond value.
        configure(2'd0, TICK_MAX, 4'd8, WIDTH_RESET);
        send_request('0, '0);
        send_request(TICK_MAX, '0);
        send_request(58'd12345, '0);

        configure(KIND_LOW, TICK_MAX, 4'd12, 8'd1);
        send_request(TICK_MAX - 58'd1, '0);
        send_request(TICK_MAX - 58'd523700000, '0);

        // Short form rounding just above a whole second.
        configure(KIND_UP, TICK_MAX, 4'd15, 8'd3);
        send_request(58'd528900, '0);
        send_request(TICKS_100_MIN, '0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            kind = 2'($urandom_range(3));
            lim  = ($urandom_range(7) == 0) ? TICK_MAX : random_ticks();
            mode = 4'($urandom_range(15));
            case ($urandom_range(3))
                0:       wid = 8'd0;
                1:       wid = 8'd255;
                2:       wid = WIDTH_RESET;
                default: wid = 8'($urandom_range(255));
            endcase
            configure(kind, lim, mode, wid);
            gaps_on = (p != QUIET_PHASE);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (gaps_on && $urandom_range(39) == 0)
                    drain_glyph_writes();
                if (kind != KIND_SAMPLED && $urandom_range(9) < 4)
                begin
                    // Land near the limit, within two minutes on either side.
                    delta   = TICK_W'($urandom_range(TICKS_PER_MIN * 2, 0));
                    elapsed = $urandom_range(1) ? lim + delta : lim - delta;
                end
                else
                    elapsed = random_ticks();
                send_request(elapsed, random_ticks());
            end
        end

        drain_glyph_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdf_pkg.sv
rtl/sdf_front.sv
rtl/sdf_queue.sv
rtl/sdf_div.sv
rtl/sdf_emit.sv
rtl/stopwatch_digit_formatter_core.sv
rtl/sdf_checker.sv
bench/stopwatch_glyph_checker.sv
bench/tb_stopwatch_digit_formatter_core.sv
